// ===== sv/psf_pkg.sv =====
// Shared types, widths and the quarter-wave sine table for the fringe pixel generator.
// Used by psf_phase_unit and phase_shift_fringe_pixel_generator_top; no dependencies.
`default_nettype none

package psf_pkg;

   // Limits and fixed-point formats
   localparam int MAX_DIM    = 4096;
   localparam int MAX_STEPS  = 64;
   localparam int PHASE_BITS = 16;
   localparam int TURN_BITS  = 12;
   localparam int TURN_SHIFT = PHASE_BITS - TURN_BITS;
   localparam int QUARTER    = 1024;
   localparam int QTR_W      = $clog2(QUARTER);

   // Field and register widths
   localparam int SIZE_W  = 13;
   localparam int COORD_W = 12;
   localparam int FP_W    = 11;
   localparam int STEP_W  = 7;
   localparam int GRAY_W  = 8;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 13;

   // Derived datapath widths
   localparam int PROD_W    = FP_W + COORD_W;
   localparam int REM_W     = SIZE_W;
   localparam int DEN_W     = SIZE_W + STEP_W;
   localparam int DIV_STEPS = PHASE_BITS + 1;
   localparam int DVD_W     = DEN_W + PHASE_BITS;
   localparam int ROM_W     = 15;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
   localparam logic [IDX_W-1:0] REG_FRINGE_PERIODS = 3'd2;
   localparam logic [IDX_W-1:0] REG_AMPLITUDE      = 3'd3;
   localparam logic [IDX_W-1:0] REG_DC_LEVEL       = 3'd4;
   localparam logic [IDX_W-1:0] REG_PHASE_STEPS    = 3'd5;

   // Word entering the phase pipeline
   typedef struct packed {
      logic                vld;
      logic                kill;
      logic [SIZE_W-1:0]   size;
      logic [COORD_W-1:0]  coord;
      logic [STEP_W-1:0]   k;
   } psf_req_type;

   // Word leaving the phase pipeline
   typedef struct packed {
      logic                 vld;
      logic                 kill;
      logic [TURN_BITS-1:0] t;
   } psf_phase_type;

   typedef logic [ROM_W-1:0] sine_rom_type [0:QUARTER];

   // Taylor series constants: pi/2 in Q30 and the term divisors (2n)(2n+1)
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_D1 = 64'd6;
   localparam longint unsigned TAYLOR_D2 = 64'd20;
   localparam longint unsigned TAYLOR_D3 = 64'd42;
   localparam longint unsigned TAYLOR_D4 = 64'd72;
   localparam longint unsigned TAYLOR_D5 = 64'd110;

   // Build the quarter-wave table at elaboration: Q30 series through x^11
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned v;
      for (int i = 0; i <= QUARTER; i++) begin
         x    = (longint'(i) * HALF_PI_Q30) >> 10;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         term = ((term * x2) >> 30) / TAYLOR_D1;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / TAYLOR_D2;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / TAYLOR_D3;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / TAYLOR_D4;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / TAYLOR_D5;
         sum  = sum - longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         v = (longint'(sum) + 64'd16384) >> 15;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[i] = ROM_W'(v);
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

// ===== sv/psf_phase_unit.sv =====
// Phase pipeline: fringe phase of one pixel as a turn index, one word per clock while advance is high.
// Depends on psf_pkg for widths and the request and phase word structs.
`default_nettype none

module psf_phase_unit
   import psf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire psf_req_type        req,
   input  wire logic [FP_W-1:0]    fringe_periods,
   input  wire logic [STEP_W-1:0]  phase_steps,
   output psf_phase_type           phase_out
);

   localparam int MOD_STEPS = PROD_W;

   // Remainder stages: periods*coord mod size, one dividend bit per stage
   logic                vld_m_ff  [0:MOD_STEPS];
   logic                kill_m_ff [0:MOD_STEPS];
   logic [REM_W-1:0]    rem_m_ff  [0:MOD_STEPS];
   logic [PROD_W-1:0]   dvd_m_ff  [0:MOD_STEPS];
   logic [SIZE_W-1:0]   size_m_ff [0:MOD_STEPS];
   logic [STEP_W-1:0]   k_m_ff    [0:MOD_STEPS];
   logic [REM_W-1:0]    rem_m_in  [1:MOD_STEPS];

   // Numerator stages
   logic                vld_n1_ff, kill_n1_ff;
   logic [DEN_W-1:0]    a_n1_ff, b_n1_ff, den_n1_ff;
   logic                vld_n2_ff, kill_n2_ff;
   logic [DEN_W-1:0]    num_n2_ff, den_n2_ff;
   logic [DEN_W:0]      sum_n2_in;

   // Division stages: (num * 2^PHASE_BITS + den/2) / den, one quotient bit per stage
   logic                 vld_d_ff  [0:DIV_STEPS];
   logic                 kill_d_ff [0:DIV_STEPS];
   logic [DEN_W-1:0]     rem_d_ff  [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] low_d_ff  [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_d_ff  [0:DIV_STEPS];
   logic [DEN_W-1:0]     den_d_ff  [0:DIV_STEPS];
   logic [DEN_W-1:0]     rem_d_in  [1:DIV_STEPS];
   logic                 ge_d_in   [1:DIV_STEPS];
   logic [DVD_W-1:0]     dvd_d_in;

   // Turn index stage
   logic                  vld_t_ff, kill_t_ff;
   logic [TURN_BITS-1:0]  t_ff;
   logic [PHASE_BITS-1:0] rnd_t_in;

   function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0]  rem,
                                                 input logic              din,
                                                 input logic [SIZE_W-1:0] size);
      logic [REM_W:0] trial;
      trial = {rem, din};
      if (trial >= {1'b0, size}) begin
         trial = trial - {1'b0, size};
      end
      return trial[REM_W-1:0];
   endfunction

   // Next remainder of every stage and quotient bit of every division stage
   always_comb begin
      for (int i = 1; i <= MOD_STEPS; i++) begin
         rem_m_in[i] = mod_step(rem_m_ff[i-1], dvd_m_ff[i-1][MOD_STEPS-i], size_m_ff[i-1]);
      end
      for (int i = 1; i <= DIV_STEPS; i++) begin
         ge_d_in[i]  = {rem_d_ff[i-1], low_d_ff[i-1][DIV_STEPS-i]} >= {1'b0, den_d_ff[i-1]};
         rem_d_in[i] = ge_d_in[i]
                       ? DEN_W'({rem_d_ff[i-1], low_d_ff[i-1][DIV_STEPS-i]}
                                - {1'b0, den_d_ff[i-1]})
                       : DEN_W'({rem_d_ff[i-1], low_d_ff[i-1][DIV_STEPS-i]});
      end
   end

   assign sum_n2_in = {1'b0, a_n1_ff} + {1'b0, b_n1_ff};
   assign dvd_d_in  = {num_n2_ff, {PHASE_BITS{1'b0}}} + DVD_W'(den_n2_ff >> 1);
   assign rnd_t_in  = quo_d_ff[DIV_STEPS][PHASE_BITS-1:0]
                      + PHASE_BITS'(1 << (TURN_SHIFT - 1));

   // Advance valid bits with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MOD_STEPS; i++) begin
            vld_m_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= DIV_STEPS; i++) begin
            vld_d_ff[i] <= 1'b0;
         end
         vld_n1_ff <= 1'b0;
         vld_n2_ff <= 1'b0;
         vld_t_ff  <= 1'b0;
      end else if (advance) begin
         vld_m_ff[0] <= req.vld;
         for (int i = 1; i <= MOD_STEPS; i++) begin
            vld_m_ff[i] <= vld_m_ff[i-1];
         end
         vld_n1_ff   <= vld_m_ff[MOD_STEPS];
         vld_n2_ff   <= vld_n1_ff;
         vld_d_ff[0] <= vld_n2_ff;
         for (int i = 1; i <= DIV_STEPS; i++) begin
            vld_d_ff[i] <= vld_d_ff[i-1];
         end
         vld_t_ff <= vld_d_ff[DIV_STEPS];
      end
   end

   // Advance payload with the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         kill_m_ff[0] <= req.kill;
         rem_m_ff[0]  <= '0;
         dvd_m_ff[0]  <= PROD_W'(fringe_periods * req.coord);
         size_m_ff[0] <= req.size;
         k_m_ff[0]    <= req.k;
         for (int i = 1; i <= MOD_STEPS; i++) begin
            kill_m_ff[i] <= kill_m_ff[i-1];
            rem_m_ff[i]  <= rem_m_in[i];
            dvd_m_ff[i]  <= dvd_m_ff[i-1];
            size_m_ff[i] <= size_m_ff[i-1];
            k_m_ff[i]    <= k_m_ff[i-1];
         end

         // Scale the remainder by N and the shift by size, form the denominator
         kill_n1_ff <= kill_m_ff[MOD_STEPS];
         a_n1_ff    <= DEN_W'(phase_steps * rem_m_ff[MOD_STEPS]);
         b_n1_ff    <= DEN_W'(k_m_ff[MOD_STEPS] * size_m_ff[MOD_STEPS]);
         den_n1_ff  <= DEN_W'(phase_steps * size_m_ff[MOD_STEPS]);

         // Wrap the numerator into one turn
         kill_n2_ff <= kill_n1_ff;
         den_n2_ff  <= den_n1_ff;
         num_n2_ff  <= (sum_n2_in >= {1'b0, den_n1_ff})
                       ? DEN_W'(sum_n2_in - {1'b0, den_n1_ff})
                       : DEN_W'(sum_n2_in);

         // Load the divider with the rounded dividend
         kill_d_ff[0] <= kill_n2_ff;
         den_d_ff[0]  <= den_n2_ff;
         rem_d_ff[0]  <= DEN_W'(dvd_d_in[DVD_W-1:DIV_STEPS]);
         low_d_ff[0]  <= dvd_d_in[DIV_STEPS-1:0];
         quo_d_ff[0]  <= '0;
         for (int i = 1; i <= DIV_STEPS; i++) begin
            kill_d_ff[i] <= kill_d_ff[i-1];
            den_d_ff[i]  <= den_d_ff[i-1];
            rem_d_ff[i]  <= rem_d_in[i];
            low_d_ff[i]  <= low_d_ff[i-1];
            quo_d_ff[i]  <= {quo_d_ff[i-1][DIV_STEPS-2:0], ge_d_in[i]};
         end

         // Round the phase fraction to a turn index
         kill_t_ff <= kill_d_ff[DIV_STEPS];
         t_ff      <= rnd_t_in[PHASE_BITS-1:TURN_SHIFT];
      end
   end

   assign phase_out.vld  = vld_t_ff;
   assign phase_out.kill = kill_t_ff;
   assign phase_out.t    = t_ff;

endmodule

`default_nettype wire

// ===== sv/phase_shift_fringe_pixel_generator_top.sv =====
// N-step phase-shift fringe pixel generator: one pixel request in, one gray word
// out, every clock. A new request is taken in every cycle while the result side
// keeps up. The pipeline runs through the bit-serial remainder (23 stages),
// numerator, phase divider (17 stages) and turn index stages, followed by the
// registered sine table read, the amplitude multiply and the output register.
// A stall on the result side holds the whole pipeline.
// Configuration is to be written through the csr_ port only while no pixel is in flight,
// not enforced by the block; an unusable setting or a pattern number of 2N or more yields gray 0.
// Top level; depends on psf_pkg and psf_phase_unit.
`default_nettype none

module phase_shift_fringe_pixel_generator_top
   import psf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [STEP_W-1:0]  req_pattern_index,
   input  wire logic [COORD_W-1:0] req_column,
   input  wire logic [COORD_W-1:0] req_row,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [GRAY_W-1:0]       rsp_gray,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [IDX_W-1:0]   csr_index,
   input  wire logic [DATA_W-1:0]  csr_data
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam int MUL_W = ROM_W + GRAY_W + 2;
   localparam int SUM_W = MUL_W + 1;

   logic [SIZE_W-1:0] image_width_ff, image_height_ff;
   logic [FP_W-1:0]   fringe_periods_ff;
   logic [GRAY_W-1:0] amplitude_ff, dc_level_ff;
   logic [STEP_W-1:0] phase_steps_ff;

   logic              advance;
   logic              cfg_bad;
   logic [STEP_W:0]   two_n;
   logic              vertical;
   psf_req_type       req_word;
   psf_phase_type     phase_word;

   logic [QTR_W:0]    rom_addr;
   logic              vld_r_ff, kill_r_ff, neg_r_ff;
   logic [ROM_W-1:0]  rom_data_ff;
   logic signed [ROM_W:0]   sine_in;
   logic              vld_p_ff, kill_p_ff;
   logic signed [MUL_W-1:0] prod_p_ff;
   logic signed [SUM_W-1:0] value_in;
   logic [SUM_W-1:0]  rounded_in;
   logic [GRAY_W-1:0] gray_in;
   logic              rsp_valid_ff;
   logic [GRAY_W-1:0] rsp_gray_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= SIZE_W'(1920);
         image_height_ff   <= SIZE_W'(1080);
         fringe_periods_ff <= FP_W'(15);
         amplitude_ff      <= GRAY_W'(100);
         dc_level_ff       <= GRAY_W'(128);
         phase_steps_ff    <= STEP_W'(4);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:    image_width_ff    <= csr_data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:   image_height_ff   <= csr_data[SIZE_W-1:0];
            REG_FRINGE_PERIODS: fringe_periods_ff <= csr_data[FP_W-1:0];
            REG_AMPLITUDE:      amplitude_ff      <= csr_data[GRAY_W-1:0];
            REG_DC_LEVEL:       dc_level_ff       <= csr_data[GRAY_W-1:0];
            REG_PHASE_STEPS:    phase_steps_ff    <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Move the whole pipeline whenever the output register can take a word
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Pick orientation, size and shift; flag pixels that come out black
   assign two_n    = {phase_steps_ff, 1'b0};
   assign vertical = req_pattern_index < phase_steps_ff;
   assign cfg_bad  = (image_width_ff == '0) || (image_height_ff == '0)
                  || (fringe_periods_ff == '0) || (phase_steps_ff == '0)
                  || (image_width_ff > SIZE_W'(MAX_DIM))
                  || (image_height_ff > SIZE_W'(MAX_DIM))
                  || (phase_steps_ff > STEP_W'(MAX_STEPS));

   assign req_word.vld   = req_valid && req_ready;
   assign req_word.kill  = cfg_bad || ({1'b0, req_pattern_index} >= two_n);
   assign req_word.size  = vertical ? image_width_ff : image_height_ff;
   assign req_word.coord = vertical ? req_column : req_row;
   assign req_word.k     = vertical ? req_pattern_index
                                    : STEP_W'(req_pattern_index - phase_steps_ff);

   psf_phase_unit u_phase (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req            (req_word),
      .fringe_periods (fringe_periods_ff),
      .phase_steps    (phase_steps_ff),
      .phase_out      (phase_word)
   );

   // Fold the turn index onto the quarter-wave table
   assign rom_addr = phase_word.t[QTR_W]
                     ? (QTR_W+1)'(QUARTER - int'(phase_word.t[QTR_W-1:0]))
                     : {1'b0, phase_word.t[QTR_W-1:0]};

   // Sign, scale, offset, round and clamp
   assign sine_in    = neg_r_ff ? -$signed({1'b0, rom_data_ff}) : $signed({1'b0, rom_data_ff});
   assign value_in   = $signed({1'b0, dc_level_ff, {ROM_W{1'b0}}}) + SUM_W'(prod_p_ff);
   assign rounded_in = SUM_W'(value_in) + SUM_W'(1 << (ROM_W - 1));

   always_comb begin
      if (kill_p_ff || value_in[SUM_W-1]) begin
         gray_in = '0;
      end else if (rounded_in[SUM_W-1:ROM_W] > (SUM_W-ROM_W)'(255)) begin
         gray_in = '1;
      end else begin
         gray_in = rounded_in[ROM_W+GRAY_W-1:ROM_W];
      end
   end

   // Valid bits of the back-end stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_r_ff     <= 1'b0;
         vld_p_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_r_ff     <= phase_word.vld;
         vld_p_ff     <= vld_r_ff;
         rsp_valid_ff <= vld_p_ff;
      end
   end

   // Table read, multiply and output payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rom_data_ff <= SINE_ROM[rom_addr];
         neg_r_ff    <= phase_word.t[QTR_W+1];
         kill_r_ff   <= phase_word.kill;
         prod_p_ff   <= $signed({1'b0, amplitude_ff}) * sine_in;
         kill_p_ff   <= kill_r_ff;
         rsp_gray_ff <= gray_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gray  = rsp_gray_ff;

   // A black pixel leaves the output register as zero
   a_kill_black : assert property (@(posedge clock) disable iff (reset)
      (vld_p_ff && kill_p_ff && advance) |=> (rsp_gray == '0))
      else $error("killed pixel produced nonzero gray");

   // A phase word waiting behind a stalled output holds its turn index
   a_phase_hold : assert property (@(posedge clock) disable iff (reset)
      (phase_word.vld && !advance) |=> $stable(phase_word.t))
      else $error("phase word changed during a stall");

   // The folded table address stays inside the quarter wave
   a_rom_range : assert property (@(posedge clock) disable iff (reset)
      phase_word.vld |-> (rom_addr <= (QTR_W+1)'(QUARTER)))
      else $error("sine table address out of range");

endmodule

`default_nettype wire
